/* src/rnc_pkg.sv */
// Shared types, constants and character mapping functions of the radix-40 name codec.
// No dependencies; every other file of the codec refers to this package by scoped names.
`default_nettype none

package rnc_pkg;

   localparam int CODE_W     = 30;          // packed code width
   localparam int RADIX      = 40;
   localparam int DIGITS     = 5;           // name characters in a code
   localparam int NAME_CHARS = 5;           // length at which name_length saturates
   localparam int DIGIT_W    = 6;
   localparam int TYPE_W     = 3;
   localparam int TYPE_OUT_W = 4;
   localparam int LEN_W      = 3;
   localparam int CHAR_W     = 8;
   localparam int WORD_W     = 32;
   localparam logic [CODE_W-1:0] TYPE_WEIGHT = CODE_W'(102400000);   // 40^5

   localparam logic [DIGIT_W-1:0] BAD_DIGIT  = 6'd40;
   localparam logic [DIGIT_W-1:0] SYM_BASE   = 6'd27;
   localparam logic [DIGIT_W-1:0] NUM_BASE   = 6'd30;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                command;
      logic [TYPE_W-1:0]      type_in;
      logic [LEN_W-1:0]       name_length;
      logic [CHAR_W-1:0]      char_in0;
      logic [CHAR_W-1:0]      char_in1;
      logic [CHAR_W-1:0]      char_in2;
      logic [CHAR_W-1:0]      char_in3;
      logic [CHAR_W-1:0]      char_in4;
      logic [WORD_W-1:0]      packed_word;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]      packed_code;
      logic                   valid_res;
      logic [TYPE_OUT_W-1:0]  type_out;
      logic [CHAR_W-1:0]      char_out0;
      logic [CHAR_W-1:0]      char_out1;
      logic [CHAR_W-1:0]      char_out2;
      logic [CHAR_W-1:0]      char_out3;
      logic [CHAR_W-1:0]      char_out4;
      logic [LEN_W-1:0]       prefix_length;
      logic                   is_empty;
   } rsp_type;

   // What one lane hands to the merge stage
   typedef struct packed {
      logic [CODE_W-1:0]      term;     // digit times its positional weight
      logic                   bad;      // character outside the symbol set
      logic [CODE_W-1:0]      quot;     // decode word divided by the lane's power of 40
   } lane_out_type;

   function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      d = BAD_DIGIT;
      if (c == CH_SPACE || c == CH_NUL) begin
         d = '0;
      end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
         d = DIGIT_W'(c - CH_UC_A + 8'd1);
      end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
         d = DIGIT_W'(c - CH_LC_A + 8'd1);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         d = DIGIT_W'(c - CH_ZERO) + NUM_BASE;
      end else if (c == CH_STAR) begin
         d = SYM_BASE;
      end else if (c == CH_DOT) begin
         d = SYM_BASE + 6'd1;
      end else if (c == CH_DASH) begin
         d = SYM_BASE + 6'd2;
      end
      return d;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d == '0) begin
         c = CH_SPACE;
      end else if (d < SYM_BASE) begin
         c = CHAR_W'(d) - 8'd1 + CH_UC_A;
      end else if (d == SYM_BASE) begin
         c = CH_STAR;
      end else if (d == SYM_BASE + 6'd1) begin
         c = CH_DOT;
      end else if (d == SYM_BASE + 6'd2) begin
         c = CH_DASH;
      end else begin
         c = CHAR_W'(d - NUM_BASE) + CH_ZERO;
      end
      return c;
   endfunction

   function automatic logic [LEN_W-1:0] prefix_len(input logic [TYPE_OUT_W-1:0] t);
      logic [LEN_W-1:0] l;
      unique case (t)
         4'd1:    l = 3'd3;
         4'd2:    l = 3'd2;
         4'd3:    l = 3'd3;
         4'd4:    l = 3'd4;
         4'd5:    l = 3'd3;
         default: l = 3'd0;
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

/* src/rnc_req_if.sv */
// Request channel of the radix-40 name codec: valid/ready handshake with one command item.
// Depends on rnc_pkg for the payload type.
`default_nettype none

interface rnc_req_if;
   logic             valid;
   logic             ready;
   rnc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rnc_rsp_if.sv */
// Response channel of the radix-40 name codec: valid/ready handshake with one result item.
// Depends on rnc_pkg for the payload type.
`default_nettype none

interface rnc_rsp_if;
   logic             valid;
   logic             ready;
   rnc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/rnc_lane.sv */
// One character lane: digit lookup and weighting for encode, reciprocal division for decode.
// Depends on rnc_pkg; instantiated once per character position by the top level.
`default_nettype none

module rnc_lane #(
   parameter int POS = 0
) (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic                        active,
   input  wire logic [rnc_pkg::CHAR_W-1:0]  char_in,
   input  wire logic [rnc_pkg::CODE_W-1:0]  word_in,
   output rnc_pkg::lane_out_type            lane_out
);

   localparam int CODE_W = rnc_pkg::CODE_W;
   localparam longint unsigned ENC_WEIGHT =
      longint'(rnc_pkg::RADIX) ** (rnc_pkg::DIGITS - 1 - POS);
   localparam longint unsigned DIVISOR =
      longint'(rnc_pkg::RADIX) ** (rnc_pkg::DIGITS - POS);
   // floor(x / D) = (x * ceil(2^S / D)) >> S for every x below 2^CODE_W
   localparam int SHIFT   = CODE_W + $clog2(DIVISOR);
   localparam int RECIP_W = CODE_W + 1;
   localparam int PROD_W  = CODE_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR);

   logic [rnc_pkg::DIGIT_W-1:0] digit;
   logic                        bad;
   logic [rnc_pkg::DIGIT_W-1:0] digit_used;
   logic [PROD_W-1:0]           prod;

   logic [CODE_W-1:0]           term_ff;
   logic                        bad_ff;
   logic [CODE_W-1:0]           quot_ff;

   always_comb begin
      digit      = rnc_pkg::char_to_digit(char_in);
      bad        = active && (digit == rnc_pkg::BAD_DIGIT);
      digit_used = (active && !bad) ? digit : '0;
      prod       = PROD_W'(word_in) * PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         term_ff <= CODE_W'(CODE_W'(digit_used) * CODE_W'(ENC_WEIGHT));
         bad_ff  <= bad;
         quot_ff <= CODE_W'(prod >> SHIFT);
      end
   end

   assign lane_out.term = term_ff;
   assign lane_out.bad  = bad_ff;
   assign lane_out.quot = quot_ff;

endmodule

`default_nettype wire

/* src/rnc_merge.sv */
// Merge stage: sums lane terms into the code, or splits lane quotients into characters.
// Depends on rnc_pkg; holds the response register of the codec.
`default_nettype none

module rnc_merge (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire rnc_pkg::cmd_type             command,
   input  wire logic [rnc_pkg::TYPE_W-1:0]   type_code,
   input  wire logic [rnc_pkg::CODE_W-1:0]   word,
   input  wire rnc_pkg::lane_out_type        lanes [rnc_pkg::DIGITS],
   output rnc_pkg::rsp_type                  rsp_data
);

   localparam int CODE_W = rnc_pkg::CODE_W;
   localparam int DIGITS = rnc_pkg::DIGITS;

   logic [CODE_W-1:0]           qv [DIGITS+1];
   logic [rnc_pkg::DIGIT_W-1:0] dig [DIGITS];
   logic [DIGITS:0]             tail;
   logic [rnc_pkg::CHAR_W-1:0]  ch [DIGITS];
   logic [CODE_W-1:0]           sum;
   logic                        any_bad;
   logic [rnc_pkg::TYPE_OUT_W-1:0] dec_type;
   logic                        has_prefix;
   rnc_pkg::rsp_type            rsp_in;
   rnc_pkg::rsp_type            rsp_ff;

   always_comb begin
      sum     = CODE_W'(type_code) * rnc_pkg::TYPE_WEIGHT;
      any_bad = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
         sum     = sum + lanes[i].term;
         any_bad = any_bad | lanes[i].bad;
      end

      // quotient by 40^(DIGITS-i); the undivided word closes the row
      for (int i = 0; i < DIGITS; i++) begin
         qv[i] = lanes[i].quot;
      end
      qv[DIGITS] = word;
      for (int i = 0; i < DIGITS; i++) begin
         dig[i] = rnc_pkg::DIGIT_W'(qv[i+1] - CODE_W'(qv[i] * CODE_W'(rnc_pkg::RADIX)));
      end
      dec_type   = rnc_pkg::TYPE_OUT_W'(qv[0]);
      has_prefix = (dec_type >= 4'd1) && (dec_type <= 4'd5);

      // drop trailing blanks; the first character only when a prefix is present
      tail[DIGITS] = 1'b1;
      for (int k = DIGITS - 1; k >= 0; k--) begin
         tail[k] = tail[k+1] && (dig[k] == '0);
      end
      for (int k = 0; k < DIGITS; k++) begin
         if (tail[k] && (k != 0 || has_prefix)) begin
            ch[k] = '0;
         end else begin
            ch[k] = rnc_pkg::digit_to_char(dig[k]);
         end
      end

      rsp_in = '0;
      unique case (command)
         rnc_pkg::CMD_ENCODE: begin
            rsp_in.packed_code = any_bad ? '0 : sum;
            rsp_in.valid_res   = !any_bad;
         end
         rnc_pkg::CMD_DECODE: begin
            rsp_in.valid_res     = 1'b1;
            rsp_in.type_out      = dec_type;
            rsp_in.char_out0     = ch[0];
            rsp_in.char_out1     = ch[1];
            rsp_in.char_out2     = ch[2];
            rsp_in.char_out3     = ch[3];
            rsp_in.char_out4     = ch[4];
            rsp_in.prefix_length = rnc_pkg::prefix_len(dec_type);
            rsp_in.is_empty      = (word == '0);
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* src/radix40_name_codec_top.sv */
// Radix-40 name codec, top level: request register, five character lanes, merge stage.
// Depends on rnc_pkg, rnc_req_if, rnc_rsp_if, rnc_lane and rnc_merge.
//
// Usage:
//   req_chan carries one command per item: encode (type, length, five ASCII
//   characters) or decode (32-bit stored word, top two bits ignored).
//   rsp_chan returns exactly one result item per command, in order.
// Pipeline: the lane registers load at the accepting edge and the response
//   register loads from them whenever it is empty or its result is taken;
//   the result is presented from the response register.
// Throughput: one item per cycle unless stalled. Each character position has its
//   own lane, so the five reciprocal multiplies and digit lookups run side by side.
// Stall: when rsp_chan.ready is low a held result stays put; the response
//   register and the lane stage still take an item while empty, so up to two
//   items wait inside before req_chan.ready falls.
// Reset: synchronous, active high; clears both stage valid flags. No other
//   state is reset, and there is no start-up pass.
`default_nettype none

module radix40_name_codec_top (
   input  wire logic    clock,
   input  wire logic    reset,
   rnc_req_if.sink      req_chan,
   rnc_rsp_if.source    rsp_chan
);

   localparam int DIGITS = rnc_pkg::DIGITS;
   localparam int LEN_W  = rnc_pkg::LEN_W;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic                         adv1, adv2;
   rnc_pkg::cmd_type             cmd_ff;
   logic [rnc_pkg::TYPE_W-1:0]   type_ff;
   logic [rnc_pkg::CODE_W-1:0]   word_ff;
   logic [rnc_pkg::CODE_W-1:0]   word_in;
   logic [LEN_W-1:0]             len_sat;
   logic [DIGITS-1:0]            lane_active;
   logic [rnc_pkg::CHAR_W-1:0]   lane_char [DIGITS];
   rnc_pkg::lane_out_type        lane_res [DIGITS];

   assign adv2 = !s2_valid_ff || rsp_chan.ready;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_chan.ready = adv1;
   assign rsp_chan.valid = s2_valid_ff;

   always_comb begin
      s1_valid_in = adv1 ? req_chan.valid : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      len_sat     = (req_chan.data.name_length > LEN_W'(rnc_pkg::NAME_CHARS))
                    ? LEN_W'(rnc_pkg::NAME_CHARS) : req_chan.data.name_length;
      word_in     = rnc_pkg::CODE_W'(req_chan.data.packed_word);
      lane_char[0] = req_chan.data.char_in0;
      lane_char[1] = req_chan.data.char_in1;
      lane_char[2] = req_chan.data.char_in2;
      lane_char[3] = req_chan.data.char_in3;
      lane_char[4] = req_chan.data.char_in4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         cmd_ff  <= req_chan.data.command;
         type_ff <= req_chan.data.type_in;
         word_ff <= word_in;
      end
   end

   for (genvar g = 0; g < DIGITS; g++) begin : g_lane
      assign lane_active[g] = (LEN_W'(g) < len_sat);

      rnc_lane #(
         .POS (g)
      ) u_lane (
         .clock    (clock),
         .load     (adv1),
         .active   (lane_active[g]),
         .char_in  (lane_char[g]),
         .word_in  (word_in),
         .lane_out (lane_res[g])
      );
   end

   rnc_merge u_merge (
      .clock     (clock),
      .load      (adv2),
      .command   (cmd_ff),
      .type_code (type_ff),
      .word      (word_ff),
      .lanes     (lane_res),
      .rsp_data  (rsp_chan.data)
   );

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff)
      else $error("accepted item did not reach the lane stage");

   a_stage1_moves_to_output: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && adv2 |=> rsp_chan.valid)
      else $error("lane stage item lost on its way to the response register");

   a_stage1_holds_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !adv2 |=> s1_valid_ff && $stable(cmd_ff) && $stable(word_ff))
      else $error("lane stage item changed while blocked");

   a_bad_encode_clears_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.data.valid_res |->
         rsp_chan.data.packed_code == '0 && rsp_chan.data.type_out == '0)
      else $error("rejected encode carries a code");

   a_empty_word_decodes_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.is_empty |->
         rsp_chan.data.type_out == '0 && rsp_chan.data.char_out4 == '0
         && rsp_chan.data.prefix_length == '0)
      else $error("empty word produced characters or a type");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for radix40_name_codec_top: encode and decode items with random gaps.
// Depends on rnc_pkg, rnc_req_if, rnc_rsp_if and the codec RTL.

module tb;
   import rnc_pkg::*;

   localparam int unsigned W5 = 102400000;   // 40^5
   localparam int unsigned W4 = 2560000;
   localparam int unsigned W3 = 64000;
   localparam int unsigned W2 = 1600;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 60;
   localparam int ITEMS_PER_PHASE = 330;

   class name_code_scoreboard;
      rsp_type expected_q[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function automatic logic [DIGIT_W-1:0] digit_of(logic [CHAR_W-1:0] c);
         logic [DIGIT_W-1:0] d;
         d = BAD_DIGIT;
         if (c == 8'h20 || c == 8'h00) d = '0;
         else if (c >= "A" && c <= "Z") d = DIGIT_W'(c - "A" + 1);
         else if (c >= "a" && c <= "z") d = DIGIT_W'(c - "a" + 1);
         else if (c >= "0" && c <= "9") d = DIGIT_W'(c - "0" + 30);
         else if (c == "*") d = 6'd27;
         else if (c == ".") d = 6'd28;
         else if (c == "-") d = 6'd29;
         return d;
      endfunction

      function automatic logic [CHAR_W-1:0] char_of(logic [DIGIT_W-1:0] d);
         logic [CHAR_W-1:0] c;
         if (d == 0) c = " ";
         else if (d < 27) c = CHAR_W'(d - 1 + "A");
         else if (d == 27) c = "*";
         else if (d == 28) c = ".";
         else if (d == 29) c = "-";
         else c = CHAR_W'(d - 30 + "0");
         return c;
      endfunction

      function automatic rsp_type convert_name(req_type item);
         rsp_type exp;
         logic [CHAR_W-1:0] ch[5];
         logic [31:0] acc;
         logic [CODE_W-1:0] rest;
         logic [DIGIT_W-1:0] d;
         logic [TYPE_OUT_W-1:0] kind;
         int len;
         int first;
         bit ok;
         bit blanks;
         exp = '0;
         if (item.command == CMD_ENCODE) begin
            ch = '{item.char_in0, item.char_in1, item.char_in2, item.char_in3, item.char_in4};
            len = (item.name_length > NAME_CHARS) ? NAME_CHARS : int'(item.name_length);
            acc = 32'(item.type_in);
            ok = 1'b1;
            for (int i = 0; i < 5; i++) begin
               d = '0;
               if (i < len) begin
                  d = digit_of(ch[i]);
                  if (d == BAD_DIGIT) begin
                     ok = 1'b0;
                     d = '0;
                  end
               end
               acc = acc * 40 + 32'(d);
            end
            exp.packed_code = ok ? acc[CODE_W-1:0] : '0;
            exp.valid_res = ok;
         end else begin
            rest = item.packed_word[CODE_W-1:0];
            exp.is_empty = (rest == 0);
            for (int k = 4; k >= 0; k--) begin
               ch[k] = char_of(DIGIT_W'(rest % 40));
               rest = rest / 40;
            end
            kind = TYPE_OUT_W'(rest);
            case (kind)
               4'd1, 4'd3, 4'd5: exp.prefix_length = 3'd3;
               4'd2:             exp.prefix_length = 3'd2;
               4'd4:             exp.prefix_length = 3'd4;
               default:          exp.prefix_length = 3'd0;
            endcase
            // without a prefix the first character is never blanked
            first = (kind >= 1 && kind <= 5) ? 0 : 1;
            blanks = 1'b1;
            for (int k = 4; k >= first; k--) begin
               if (ch[k] != " ") blanks = 1'b0;
               if (blanks) ch[k] = 8'h00;
            end
            exp.valid_res = 1'b1;
            exp.type_out = kind;
            exp.char_out0 = ch[0];
            exp.char_out1 = ch[1];
            exp.char_out2 = ch[2];
            exp.char_out3 = ch[3];
            exp.char_out4 = ch[4];
         end
         return exp;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("tb: %0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      endtask

      function void note_request(req_type item);
         expected_q.push_back(convert_name(item));
      endfunction

      task check_field(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) report_mismatch(what, got, want);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result, packed_code", 32'(got.packed_code), 32'h0);
         end else begin
            want = expected_q.pop_front();
            check_field("packed_code", 32'(got.packed_code), 32'(want.packed_code));
            check_field("valid_res", 32'(got.valid_res), 32'(want.valid_res));
            check_field("type_out", 32'(got.type_out), 32'(want.type_out));
            check_field("char_out0", 32'(got.char_out0), 32'(want.char_out0));
            check_field("char_out1", 32'(got.char_out1), 32'(want.char_out1));
            check_field("char_out2", 32'(got.char_out2), 32'(want.char_out2));
            check_field("char_out3", 32'(got.char_out3), 32'(want.char_out3));
            check_field("char_out4", 32'(got.char_out4), 32'(want.char_out4));
            check_field("prefix_length", 32'(got.prefix_length), 32'(want.prefix_length));
            check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off_req;
   name_code_scoreboard sb = new();

   rnc_req_if req_chan ();
   rnc_rsp_if rsp_chan ();

   radix40_name_codec_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic req_type noise_item();
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      return req_type'(raw[$bits(req_type)-1:0]);
   endfunction

   function automatic req_type encode_item(logic [2:0] kind, logic [2:0] len,
                                           logic [39:0] name);
      req_type item;
      item = noise_item();
      item.command = CMD_ENCODE;
      item.type_in = kind;
      item.name_length = len;
      {item.char_in0, item.char_in1, item.char_in2, item.char_in3, item.char_in4} = name;
      return item;
   endfunction

   function automatic req_type decode_item(logic [31:0] word);
      req_type item;
      item = noise_item();
      item.command = CMD_DECODE;
      item.packed_word = word;
      return item;
   endfunction

   function automatic logic [7:0] name_symbol();
      logic [7:0] c;
      case ($urandom_range(6))
         0:       c = $urandom_range(1) ? 8'h20 : 8'h00;
         1:       c = 8'("a" + $urandom_range(25));
         2:       c = 8'("0" + $urandom_range(9));
         3:       c = ($urandom_range(2) == 0) ? "*" : ($urandom_range(1) ? "." : "-");
         default: c = 8'("A" + $urandom_range(25));
      endcase
      return c;
   endfunction

   // Build a word with a chosen type and a run of trailing blank digits
   function automatic logic [31:0] shaped_word();
      logic [31:0] w;
      int blanks;
      w = $urandom_range(10);
      blanks = $urandom_range(5);
      for (int k = 0; k < 5; k++) w = w * 40 + ((k >= 5 - blanks) ? 0 : $urandom_range(39));
      if (w > 32'h3FFFFFFF) w = w - W5;
      w[31:30] = 2'($urandom_range(3));
      return w;
   endfunction

   function automatic req_type random_item();
      req_type item;
      logic [39:0] name;
      int spoil;
      item = noise_item();
      if ($urandom_range(1)) begin
         for (int i = 0; i < 5; i++) name[39 - 8*i -: 8] = name_symbol();
         // spoil one character now and then
         if ($urandom_range(9) == 0) begin
            spoil = $urandom_range(4);
            name[39 - 8*spoil -: 8] = 8'($urandom);
         end
         if ($urandom_range(1)) item.name_length = 3'd5;
         item = encode_item(item.type_in, item.name_length, name);
      end else begin
         item = decode_item($urandom_range(1) ? shaped_word() : $urandom);
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) send_item(random_item());
   endtask

   // Result side: random back-pressure, plus a long hold when asked
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.data);
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      logic [7:0] bad_chars[8];
      bad_chars = '{8'h1F, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF};
      reset = 1'b1;
      hold_off_req = 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 71;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unused characters are never checked, so junk beyond the length is fine
      send_item(encode_item(3'd0, 3'd0, {5{8'hFF}}));
      send_item(encode_item(3'd7, 3'd5, "zzzzz"));
      send_item(encode_item(3'd7, 3'd7, "99999"));
      send_item(encode_item(3'd1, 3'd5, "AZaz*"));
      send_item(encode_item(3'd2, 3'd5, ".-09 "));
      send_item(encode_item(3'd3, 3'd3, {"AB", 8'h00, "@@"}));
      send_item(encode_item(3'd5, 3'd6, {5{8'h00}}));
      for (int i = 0; i < 8; i++)
         send_item(encode_item(3'd4, 3'd5, ("A-*.0" & ~(40'hFF << (8 * (i % 5))))
                                           | (40'(bad_chars[i]) << (8 * (i % 5)))));
      send_item(decode_item(32'h0000_0000));
      send_item(decode_item(32'hC000_0000));
      send_item(decode_item(32'hFFFF_FFFF));
      send_item(decode_item(W5 + W4 + 2 * W3));
      send_item(decode_item(W4));
      send_item(decode_item(6 * W5));
      send_item(decode_item(5 * W5));
      send_item(decode_item(3 * W5 + 39 * (W4 + W3 + W2 + 40 + 1)));
      send_item(decode_item(32'h8000_0000 | (2 * W5 + 28 * W2)));
      send_random(ITEMS_PER_PHASE);

      wait_drained();
      send_idle_pct = 71;
      recv_idle_pct = 14;
      send_random(ITEMS_PER_PHASE);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req = 1'b1;
      send_random(ITEMS_PER_PHASE);

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) sb.report_mismatch("results still owed", sb.pending(), 0);
      if (sb.mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

/* radix40_name_codec_top.f */
src/rnc_pkg.sv
src/rnc_req_if.sv
src/rnc_rsp_if.sv
src/rnc_lane.sv
src/rnc_merge.sv
src/radix40_name_codec_top.sv
bench/tb.sv
